// ===== hw/rtl/rmf_pkg.sv =====
`timescale 1ns / 1ps

package rmf_pkg;

  localparam int ADDR_W              = 32;
  localparam int PLEN_W              = 6;
  localparam int USED_W              = 7;
  localparam int DEFAULT_TABLE_DEPTH = 64;

  localparam logic [PLEN_W-1:0] PLEN_MAX = PLEN_W'(ADDR_W);

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_RANGE  = 2'd1,
    OP_PREFIX = 2'd2,
    OP_QUERY  = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_FULL       = 2'd1,
    ST_BAD_PREFIX = 2'd2
  } status_t;

  typedef struct packed {
    opcode_t             opcode;
    logic [ADDR_W-1:0]   address;
    logic [ADDR_W-1:0]   range_end;
    logic [PLEN_W-1:0]   prefix_len;
  } in_item_t;

  typedef struct packed {
    logic                keep;
    logic                hit;
    status_t             status;
    logic [USED_W-1:0]   entries_used;
  } out_item_t;

  typedef struct packed {
    logic                vld;
    opcode_t             op;
    logic [ADDR_W-1:0]   lo;
    logic [ADDR_W-1:0]   hi;
    logic                hit;
    logic                placed;
  } token_t;

endpackage

// ===== hw/rtl/ipv4_range_membership_filter.sv =====
`timescale 1ns / 1ps
// Each transaction walks the row of TABLE_DEPTH range cells, one cell per cycle, before
// the next is taken; out_valid is registered from the token that leaves the row end.
// A result waiting in the output register stalls the row only when it reaches the end.
// Reset (rst, synchronous): table empty, count zero, filter_mode = 1 (intersect).

module ipv4_range_membership_filter #(
  parameter int TABLE_DEPTH = rmf_pkg::DEFAULT_TABLE_DEPTH
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  rmf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rmf_pkg::out_item_t out_data,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data
);

  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  rmf_pkg::token_t            chain [TABLE_DEPTH+1];
  rmf_pkg::token_t            launch;
  logic                       busy;
  logic                       advance;
  logic                       accept;
  logic                       exit_load;
  logic                       filter_mode;
  logic [CNT_W-1:0]           count;
  logic [CNT_W-1:0]           count_next;
  rmf_pkg::status_t           status_next;
  rmf_pkg::status_t           pend_status;
  logic [CNT_W-1:0]           pend_count;
  logic                       bad_plen;
  logic                       full;
  logic                       is_add;
  logic                       store;
  logic [rmf_pkg::PLEN_W-1:0] shamt;
  logic [rmf_pkg::ADDR_W-1:0] mask;
  logic                       res_hit;

  assign in_ready  = !busy && !rst;
  assign accept    = in_valid && in_ready;
  assign advance   = !(chain[TABLE_DEPTH].vld && out_valid && !out_ready);
  assign exit_load = chain[TABLE_DEPTH].vld && advance;

  assign is_add   = (in_data.opcode == rmf_pkg::OP_RANGE) ||
                    (in_data.opcode == rmf_pkg::OP_PREFIX);
  assign bad_plen = (in_data.opcode == rmf_pkg::OP_PREFIX) &&
                    (in_data.prefix_len > rmf_pkg::PLEN_MAX);
  assign full     = (count == CNT_W'(TABLE_DEPTH));
  assign store    = is_add && !bad_plen && !full;
  assign shamt    = rmf_pkg::PLEN_MAX - in_data.prefix_len;
  assign mask     = (in_data.prefix_len == '0) ? '0 : ({rmf_pkg::ADDR_W{1'b1}} << shamt);

  always_comb begin
    count_next  = count;
    status_next = rmf_pkg::ST_OK;
    if (in_data.opcode == rmf_pkg::OP_CLEAR) begin
      count_next = '0;
    end else if (store) begin
      count_next = CNT_W'(count + 1'b1);
    end
    priority if (bad_plen) begin
      status_next = rmf_pkg::ST_BAD_PREFIX;
    end else if (is_add && full) begin
      status_next = rmf_pkg::ST_FULL;
    end else begin
      status_next = rmf_pkg::ST_OK;
    end
  end

  always_comb begin
    launch        = '0;
    launch.vld    = accept;
    launch.op     = in_data.opcode;
    launch.lo     = in_data.address;
    launch.hi     = in_data.range_end;
    launch.hit    = 1'b0;
    launch.placed = !store;
    if (in_data.opcode == rmf_pkg::OP_PREFIX) begin
      launch.lo = in_data.address & mask;
      launch.hi = (in_data.address & mask) | ~mask;
    end
  end

  assign chain[0] = launch;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    rmf_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .tok_in  (chain[i]),
      .tok_out (chain[i+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy        <= 1'b0;
      count       <= '0;
      filter_mode <= 1'b1;
    end else begin
      if (cfg_wr_en) begin
        filter_mode <= cfg_wr_data;
      end
      if (accept) begin
        busy  <= 1'b1;
        count <= count_next;
      end else if (exit_load) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      pend_status <= status_next;
      pend_count  <= count_next;
    end
  end

  assign res_hit = (chain[TABLE_DEPTH].op == rmf_pkg::OP_QUERY) && chain[TABLE_DEPTH].hit;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exit_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exit_load) begin
      out_data.hit          <= res_hit;
      out_data.keep         <= (chain[TABLE_DEPTH].op == rmf_pkg::OP_QUERY) &&
                               (filter_mode ? res_hit : !res_hit);
      out_data.status       <= pend_status;
      out_data.entries_used <= rmf_pkg::USED_W'(pend_count);
    end
  end

`ifndef NO_ASSERTIONS
  a_idle_no_token: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !chain[TABLE_DEPTH].vld)
    else $error("token at row end while idle");

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("busy not set after transaction");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count above table depth");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    busy && pend_status == rmf_pkg::ST_FULL |-> count == CNT_W'(TABLE_DEPTH))
    else $error("full status with free entries");
`endif

endmodule

// ===== hw/rtl/rmf_cell.sv =====
`timescale 1ns / 1ps

module rmf_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  rmf_pkg::token_t tok_in,
  output rmf_pkg::token_t tok_out
);

  logic [rmf_pkg::ADDR_W-1:0] entry_lo;
  logic [rmf_pkg::ADDR_W-1:0] entry_hi;
  logic                       entry_vld;
  logic                       contains;
  logic                       take;
  logic                       is_add;
  rmf_pkg::token_t            tok_next;

  assign contains = entry_vld && (tok_in.lo >= entry_lo) && (tok_in.lo <= entry_hi);
  assign is_add   = (tok_in.op == rmf_pkg::OP_RANGE) || (tok_in.op == rmf_pkg::OP_PREFIX);
  assign take     = tok_in.vld && is_add && !tok_in.placed && !entry_vld;

  always_comb begin
    tok_next = tok_in;
    if (tok_in.op == rmf_pkg::OP_QUERY) begin
      tok_next.hit = tok_in.hit | contains;
    end
    if (take) begin
      tok_next.placed = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && take) begin
      entry_lo <= tok_in.lo;
      entry_hi <= tok_in.hi;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_vld <= 1'b0;
    end else if (advance && tok_in.vld) begin
      if (tok_in.op == rmf_pkg::OP_CLEAR) begin
        entry_vld <= 1'b0;
      end else if (take) begin
        entry_vld <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out <= '0;
    end else if (advance) begin
      tok_out <= tok_next;
    end
  end

endmodule

// ===== tb/sv/ipv4_range_membership_filter_test.sv =====
`timescale 1ns / 1ps

module ipv4_range_membership_filter_test;
  import rmf_pkg::*;

  localparam int DEPTH  = DEFAULT_TABLE_DEPTH;
  localparam int SETTLE = DEPTH + 8;

  logic      clk         = 1'b0;
  logic      rst         = 1'b1;
  logic      in_valid    = 1'b0;
  logic      in_ready;
  in_item_t  in_data     = '0;
  logic      out_valid;
  logic      out_ready   = 1'b0;
  out_item_t out_data;
  logic      cfg_wr_en   = 1'b0;
  logic      cfg_wr_data = 1'b0;

  always #4 clk = ~clk;

  ipv4_range_membership_filter #(
    .TABLE_DEPTH(DEPTH)
  ) i_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  logic [ADDR_W-1:0] range_lo [DEPTH];
  logic [ADDR_W-1:0] range_hi [DEPTH];
  bit                range_set [DEPTH];
  int unsigned       ranges_stored  = 0;
  bit                keep_members   = 1'b1;
  out_item_t         pending_results[$];

  int mismatches     = 0;
  int send_idle_pct  = 0;
  int sink_stall_pct = 0;
  int hold_len       = 0;
  int hold_left      = 0;

  function automatic logic [ADDR_W-1:0] prefix_bits(logic [PLEN_W-1:0] len);
    if (len == 0) return '0;
    return {ADDR_W{1'b1}} << (ADDR_W - len);
  endfunction

  function automatic status_t store_range(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
    if (ranges_stored >= DEPTH) return ST_FULL;
    range_lo[ranges_stored]  = lo;
    range_hi[ranges_stored]  = hi;
    range_set[ranges_stored] = 1'b1;
    ranges_stored++;
    return ST_OK;
  endfunction

  function automatic bit any_range_holds(logic [ADDR_W-1:0] a);
    bit found;
    found = 1'b0;
    for (int i = 0; i < DEPTH; i++) begin
      if (range_set[i] && a >= range_lo[i] && a <= range_hi[i]) found = 1'b1;
    end
    return found;
  endfunction

  function automatic out_item_t filter_predict(in_item_t it);
    out_item_t         r;
    logic [ADDR_W-1:0] m;
    r = '0;
    case (it.opcode)
      OP_CLEAR: begin
        for (int i = 0; i < DEPTH; i++) range_set[i] = 1'b0;
        ranges_stored = 0;
      end
      OP_RANGE: begin
        r.status = store_range(it.address, it.range_end);
      end
      OP_PREFIX: begin
        if (it.prefix_len > PLEN_MAX) begin
          r.status = ST_BAD_PREFIX;
        end else begin
          m = prefix_bits(it.prefix_len);
          r.status = store_range(it.address & m, (it.address & m) | ~m);
        end
      end
      default: begin
        r.hit  = any_range_holds(it.address);
        r.keep = keep_members ? r.hit : ~r.hit;
      end
    endcase
    r.entries_used = USED_W'(ranges_stored);
    return r;
  endfunction

  function automatic in_item_t make_item(opcode_t op, logic [ADDR_W-1:0] addr,
                                         logic [ADDR_W-1:0] rend, logic [PLEN_W-1:0] plen);
    in_item_t it;
    it.opcode     = op;
    it.address    = addr;
    it.range_end  = rend;
    it.prefix_len = plen;
    return it;
  endfunction

  task automatic report_mismatch(string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic send_item(in_item_t it);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(filter_predict(it));
  endtask

  task automatic send_clear();
    send_item(make_item(OP_CLEAR, $urandom, $urandom, PLEN_W'($urandom)));
  endtask

  task automatic send_range(logic [ADDR_W-1:0] lo, logic [ADDR_W-1:0] hi);
    send_item(make_item(OP_RANGE, lo, hi, PLEN_W'($urandom)));
  endtask

  task automatic send_prefix(logic [ADDR_W-1:0] base, logic [PLEN_W-1:0] len);
    send_item(make_item(OP_PREFIX, base, $urandom, len));
  endtask

  task automatic send_query(logic [ADDR_W-1:0] a);
    send_item(make_item(OP_QUERY, a, $urandom, PLEN_W'($urandom)));
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_mode(bit m);
    wait_for_results();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= m;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    keep_members = m;
  endtask

  function automatic logic [ADDR_W-1:0] pick_address();
    int unsigned       i;
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    if (ranges_stored == 0 || $urandom_range(9) < 3) return $urandom;
    i  = $urandom_range(ranges_stored - 1);
    lo = range_lo[i];
    hi = range_hi[i];
    case ($urandom_range(4))
      0: return lo;
      1: return hi;
      2: return lo - 1;
      3: return hi + 1;
      default: return lo + $urandom_range(255);
    endcase
  endfunction

  task automatic send_random_add();
    logic [ADDR_W-1:0] lo;
    logic [ADDR_W-1:0] hi;
    lo = $urandom;
    if ($urandom_range(1) == 0) begin
      case ($urandom_range(9))
        0: hi = $urandom;
        1: hi = lo - 1 - $urandom_range(100);
        2: begin
          lo = '0;
          hi = $urandom_range(65535);
        end
        3: begin
          hi = '1;
          lo = hi - $urandom_range(65535);
        end
        default: hi = lo + $urandom_range(4095);
      endcase
      send_range(lo, hi);
    end else if ($urandom_range(9) == 0) begin
      send_prefix(lo, PLEN_W'($urandom_range(63)));
    end else begin
      send_prefix(lo, PLEN_W'($urandom_range(12, ADDR_W)));
    end
  endtask

  task automatic random_session(int n);
    int done;
    int n_add;
    int n_q;
    done = 0;
    while (done < n) begin
      if ($urandom_range(3) != 0) begin
        send_clear();
        done++;
      end
      n_add = ($urandom_range(19) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 10);
      repeat (n_add) begin
        send_random_add();
        done++;
      end
      n_q = $urandom_range(5, 20);
      repeat (n_q) begin
        if ($urandom_range(9) == 0) begin
          send_item(make_item(opcode_t'(2'($urandom_range(3))), $urandom, $urandom,
                              PLEN_W'($urandom_range(63))));
        end else begin
          send_query(pick_address());
        end
        done++;
      end
    end
  endtask

  task automatic test_empty_table();
    send_query('0);
    send_query('1);
    set_mode(1'b0);
    send_query('0);
    send_query('1);
    send_query($urandom);
    set_mode(1'b1);
  endtask

  task automatic test_range_and_prefix();
    send_clear();
    send_range(32'h0A00_0000, 32'h0AFF_FFFF);
    send_query(32'h0A00_0000);
    send_query(32'h0AFF_FFFF);
    send_query(32'h09FF_FFFF);
    send_query(32'h0B00_0000);
    send_prefix(32'hC0A8_014D, 6'd24);
    send_query(32'hC0A8_0100);
    send_query(32'hC0A8_01FF);
    send_query(32'hC0A8_0200);
    send_prefix(32'hDEAD_BEEF, 6'd32);
    send_query(32'hDEAD_BEEF);
    send_query(32'hDEAD_BEF0);
    send_prefix(32'h1234_5678, 6'd33);
    send_prefix(32'h1234_5678, 6'd63);
    send_range(32'h0000_0050, 32'h0000_0040);
    send_query(32'h0000_0048);
    send_range(32'd1000, 32'd2000);
    send_range(32'd1500, 32'd3000);
    send_query(32'd2500);
    send_query(32'd3001);
    send_range('1, '1);
    send_query('1);
    set_mode(1'b0);
    send_query(32'd1200);
    send_query(32'd5000);
    send_prefix('1, 6'd0);
    send_query('0);
    send_clear();
    send_query('0);
    set_mode(1'b1);
  endtask

  task automatic test_table_full();
    send_clear();
    for (int i = 0; i < DEPTH; i++) begin
      send_range(i * 32'h1000, i * 32'h1000 + 32'hFF);
    end
    send_range(32'h8000_0000, 32'h8000_00FF);
    send_prefix(32'h9000_0000, 6'd16);
    send_prefix(32'h9000_0000, 6'd40);
    send_query((DEPTH - 1) * 32'h1000 + 32'h80);
    send_query((DEPTH - 1) * 32'h1000 + 32'h100);
    send_clear();
    send_query(32'h80);
  endtask

  task automatic test_output_hold();
    wait_for_results();
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    send_range(32'h2000_0000, 32'h2FFF_FFFF);
    hold_len = 400;
    repeat (8) send_query(pick_address());
    wait_for_results();
  endtask

  task automatic test_random_traffic();
    set_mode(1'b0);
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    random_session(150);
    set_mode(1'b1);
    send_idle_pct  = 56;
    sink_stall_pct = 0;
    random_session(150);
    set_mode(1'b0);
    send_idle_pct  = 0;
    sink_stall_pct = 56;
    random_session(150);
    set_mode(1'b1);
    send_idle_pct  = 14;
    sink_stall_pct = 14;
    random_session(150);
    send_idle_pct  = 0;
    sink_stall_pct = 0;
  endtask

  always @(posedge clk) begin
    if (hold_len != 0) begin
      hold_left = hold_len;
      hold_len  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end
  end

  always @(posedge clk) begin : check_results
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("unexpected transaction %h", out_data));
      end else begin
        want = pending_results.pop_front();
        if (out_data.keep !== want.keep)
          report_mismatch($sformatf("keep %b, want %b", out_data.keep, want.keep));
        if (out_data.hit !== want.hit)
          report_mismatch($sformatf("hit %b, want %b", out_data.hit, want.hit));
        if (out_data.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_data.status, want.status));
        if (out_data.entries_used !== want.entries_used)
          report_mismatch($sformatf("entries_used %0d, want %0d",
                                    out_data.entries_used, want.entries_used));
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_empty_table();
    test_range_and_prefix();
    test_table_full();
    test_output_hold();
    test_random_traffic();
    wait_for_results();
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("ipv4_range_membership_filter_test: PASS");
    end else begin
      $display("ipv4_range_membership_filter_test: FAIL");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("ipv4_range_membership_filter_test: FAIL");
    $finish;
  end

endmodule
